// File: design/sgdr_pkg.sv
// package: shared types and constants for the sandpile block
`timescale 1ns / 1ps
`default_nettype none
package sgdr_pkg;
  localparam int BOARD_SIZE = 16;
  localparam int COORD_W = 4;
  localparam int CELLS = BOARD_SIZE * BOARD_SIZE;
  localparam int IDX_W = $clog2(CELLS);
  localparam int GRAIN_W = 4;
  // grid entries hold the grains that pile up on a cell during relaxation
  localparam int CELL_W = 6;
  localparam int TCNT_W = 16;
  localparam logic [TCNT_W-1:0] COUNT_MAX = '1;
  localparam logic [3:0] MIN_THRESHOLD = 4'd3;
  localparam logic [3:0] THRESHOLD_RESET = 4'd4;
  localparam logic OP_DROP = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic [1:0] ADDR_THRESHOLD = 2'd0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DROP_RD,
    ST_DROP_WR,
    ST_SCAN_RD,
    ST_CELL,
    ST_NBR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [0:0] opcode;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
  } req_t;

  typedef struct packed {
    logic [GRAIN_W-1:0] cell_count;
    logic [TCNT_W-1:0] topple_count;
    logic [0:0] count_saturated;
  } rsp_t;
endpackage
`default_nettype wire

// File: design/sgdr_if.sv
// interfaces: valid/ready channels for requests and results
`timescale 1ns / 1ps
`default_nettype none
interface sgdr_req_if;
  logic valid;
  logic ready;
  sgdr_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sgdr_rsp_if;
  logic valid;
  logic ready;
  sgdr_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/sandpile_grain_drop_relax.sv
// top level: sandpile grid with drop, relaxation and cell read
//
// requests arrive on req (opcode, cell_row, cell_col); one result per
// request leaves on rsp. a read goes straight from idle to the done
// state, where its result is registered once the output register is
// free. a drop adds a grain and relaxes the grid by sweeping it in
// raster order until a full pass sees no cell above the threshold. each
// toppling is a read-modify-write of the cell and its four neighbors
// through the single read and single write port of the grid memory. a
// drop on a stable grid gives its result after one full sweep;
// avalanches add sweeps. one request is in work at a time; the next is
// taken as soon as the block is idle, while an earlier result may still
// wait in the output register. a stalled receiver holds that result, and
// the block then stops with its next result ready and takes no further
// request. after reset the grid memory is cleared by a pass over all
// cells during which no request is taken; the threshold register
// resets to 4, is written over apb at address 0; below 3 it acts as 3.
`timescale 1ns / 1ps
`default_nettype none
module sandpile_grain_drop_relax (
  input  wire logic clk,
  input  wire logic rst,
  sgdr_req_if.sink req,
  sgdr_rsp_if.source rsp,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int IW = sgdr_pkg::IDX_W;
  localparam int GW = sgdr_pkg::GRAIN_W;
  localparam int MW = sgdr_pkg::CELL_W;
  localparam int CW = sgdr_pkg::COORD_W;

  logic [MW-1:0] grid [sgdr_pkg::CELLS];
  logic [MW-1:0] rdata;
  logic [IW-1:0] raddr, waddr;
  logic [MW-1:0] wdata;
  logic we;

  sgdr_pkg::state_t state, state_next;
  logic [3:0] topple_threshold;
  logic [IW:0] cnt;
  logic [IW-1:0] cur;
  logic [2:0] nb;
  logic dirty;
  logic [sgdr_pkg::TCNT_W-1:0] tcnt;
  logic sat;
  logic rq_op;
  logic [3:0] thr;
  logic [MW-1:0] thr_ext;
  logic [CW-1:0] crow, ccol;
  logic nb_ok;
  logic [IW-1:0] nb_idx;
  logic is_last;
  logic rsp_free;

  assign pready = 1'b1;
  assign prdata = {28'd0, topple_threshold};
  assign thr = (topple_threshold < sgdr_pkg::MIN_THRESHOLD) ? sgdr_pkg::MIN_THRESHOLD
             : topple_threshold;
  assign thr_ext = MW'(thr);
  assign crow = cur[IW-1 -: CW];
  assign ccol = cur[CW-1:0];
  assign is_last = (cur == IW'(sgdr_pkg::CELLS - 1));
  assign rsp_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      topple_threshold <= sgdr_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && paddr == sgdr_pkg::ADDR_THRESHOLD) begin
      topple_threshold <= pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      grid[waddr] <= wdata;
    end
    rdata <= grid[raddr];
  end

  // neighbor selection: up, down, left, right
  always_comb begin
    nb_ok = 1'b0;
    nb_idx = cur;
    case (nb)
      3'd0: begin
        nb_ok = crow != '0;
        nb_idx = {crow - CW'(1), ccol};
      end
      3'd1: begin
        nb_ok = crow != '1;
        nb_idx = {crow + CW'(1), ccol};
      end
      3'd2: begin
        nb_ok = ccol != '0;
        nb_idx = {crow, ccol - CW'(1)};
      end
      3'd3: begin
        nb_ok = ccol != '1;
        nb_idx = {crow, ccol + CW'(1)};
      end
      default: begin
        nb_ok = 1'b0;
        nb_idx = cur;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      sgdr_pkg::ST_CLEAR: if (cnt[IW]) state_next = sgdr_pkg::ST_IDLE;
      sgdr_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = (req.payload.opcode == sgdr_pkg::OP_READ)
                     ? sgdr_pkg::ST_DONE : sgdr_pkg::ST_DROP_RD;
        end
      end
      sgdr_pkg::ST_DROP_RD: state_next = sgdr_pkg::ST_DROP_WR;
      sgdr_pkg::ST_DROP_WR: state_next = sgdr_pkg::ST_SCAN_RD;
      sgdr_pkg::ST_SCAN_RD: state_next = sgdr_pkg::ST_CELL;
      sgdr_pkg::ST_CELL: begin
        if (rdata > thr_ext) state_next = sgdr_pkg::ST_NBR;
        else if (is_last && !dirty) state_next = sgdr_pkg::ST_DONE;
        else state_next = sgdr_pkg::ST_SCAN_RD;
      end
      sgdr_pkg::ST_NBR: if (nb == 3'd4 && cnt[0]) state_next = sgdr_pkg::ST_SCAN_RD;
      sgdr_pkg::ST_DONE: if (rsp_free) state_next = sgdr_pkg::ST_IDLE;
      default: state_next = sgdr_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    raddr = cur;
    waddr = cur;
    wdata = '0;
    we = 1'b0;
    case (state)
      sgdr_pkg::ST_CLEAR: begin
        we = !cnt[IW];
        waddr = cnt[IW-1:0];
      end
      sgdr_pkg::ST_IDLE: raddr = {req.payload.cell_row, req.payload.cell_col};
      sgdr_pkg::ST_DROP_WR: begin
        we = 1'b1;
        wdata = rdata + MW'(1);
      end
      sgdr_pkg::ST_CELL: begin
        we = rdata > thr_ext;
        wdata = rdata - MW'(4);
      end
      sgdr_pkg::ST_NBR: begin
        raddr = nb_idx;
        waddr = nb_idx;
        we = cnt[0] && nb_ok && nb != 3'd4;
        wdata = rdata + MW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgdr_pkg::ST_CLEAR;
      cnt <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sgdr_pkg::ST_DONE && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        sgdr_pkg::ST_CLEAR: cnt <= cnt + (IW+1)'(1);
        sgdr_pkg::ST_IDLE: begin
          if (req.valid) begin
            rq_op <= req.payload.opcode;
            cur <= {req.payload.cell_row, req.payload.cell_col};
            tcnt <= '0;
            sat <= 1'b0;
          end
        end
        sgdr_pkg::ST_DROP_WR: begin
          cur <= '0;
          dirty <= 1'b0;
        end
        sgdr_pkg::ST_CELL: begin
          if (rdata > thr_ext) begin
            dirty <= 1'b1;
            nb <= 3'd0;
            cnt <= '0;
            if (tcnt != sgdr_pkg::COUNT_MAX) tcnt <= tcnt + sgdr_pkg::TCNT_W'(1);
            if (tcnt == sgdr_pkg::COUNT_MAX - sgdr_pkg::TCNT_W'(1)) sat <= 1'b1;
          end else begin
            if (is_last) dirty <= 1'b0;
            cur <= cur + IW'(1);
          end
        end
        sgdr_pkg::ST_NBR: begin
          cnt[0] <= !cnt[0];
          if (cnt[0]) nb <= nb + 3'd1;
        end
        sgdr_pkg::ST_DONE: begin
          if (rsp_free) begin
            rsp.payload.cell_count <= (rq_op == sgdr_pkg::OP_READ) ? rdata[GW-1:0] : '0;
            rsp.payload.topple_count <= (rq_op == sgdr_pkg::OP_READ) ? '0 : tcnt;
            rsp.payload.count_saturated <= (rq_op == sgdr_pkg::OP_READ) ? 1'b0 : sat;
          end
        end
        default: ;
      endcase
    end
  end

  assign req.ready = (state == sgdr_pkg::ST_IDLE);

`ifndef SYNTHESIS
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == sgdr_pkg::ST_CLEAR |-> !req.ready) else $error("request taken during clear");
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.count_saturated |-> rsp.payload.topple_count == sgdr_pkg::COUNT_MAX)
    else $error("saturation flag without max count");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    state == sgdr_pkg::ST_DONE |=> rsp.valid) else $error("result lost");
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) && rsp.payload.cell_count != '0 |-> rsp.payload.topple_count == '0)
    else $error("read with topplings");
`endif
endmodule
`default_nettype wire
